>>> rtl/core/eulr_pkg.sv
// Package: shared constants and helpers for the Euler XYZ rotation matrix core.
`default_nettype none
package eulr_pkg;
  localparam int unsigned CW = 34;  // CORDIC word width, Q2.30 plus guard bits
  localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;

  // Arctangent of 2^-i in Q2.30, rounded to nearest.
  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] v;
    v = '0;
    unique case (i)
      0: v = 34'sd843314857;
      1: v = 34'sd497837830;
      2: v = 34'sd263043837;
      3: v = 34'sd133525159;
      4: v = 34'sd67021687;
      5: v = 34'sd33543516;
      6: v = 34'sd16775851;
      7: v = 34'sd8388437;
      8: v = 34'sd4194283;
      9: v = 34'sd2097149;
      default: v = (i < 31) ? (34'sd1 <<< (30 - i)) : '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/eulr_if.sv
// Interfaces: input angle channel and output matrix channel.
`default_nettype none
interface eulr_in_if #(parameter int ANGLE_BITS = 16);
  logic valid;
  logic ready;
  logic signed [ANGLE_BITS-1:0] angle_x;
  logic signed [ANGLE_BITS-1:0] angle_y;
  logic signed [ANGLE_BITS-1:0] angle_z;
  modport source (output valid, angle_x, angle_y, angle_z, input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface eulr_out_if #(parameter int COEF_BITS = 16);
  logic valid;
  logic ready;
  logic signed [COEF_BITS-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                output ready);
endinterface
`default_nettype wire

>>> rtl/core/eulr_cordic.sv
// Pipelined CORDIC: one stage per step, folded angle in, rounded sin/cos out.
`default_nettype none
module eulr_cordic
  import eulr_pkg::*;
#(
  parameter int ANGLE_BITS   = 16,
  parameter int COEF_BITS    = 16,
  parameter int SINCOS_STEPS = 14
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [ANGLE_BITS-1:0] angle,
  output logic signed [COEF_BITS-1:0]      sin_o,
  output logic signed [COEF_BITS-1:0]      cos_o
);
  localparam int N = SINCOS_STEPS;
  localparam int SH = 32 - COEF_BITS;

  logic signed [CW-1:0] x_r [0:N];
  logic signed [CW-1:0] y_r [0:N];
  logic signed [CW-1:0] z_r [0:N];
  logic                 neg_r [0:N];
  logic signed [CW-1:0] z_in;
  logic signed [COEF_BITS-1:0] sin_r, cos_r;

  // Input stage: scale to Q2.30 and fold into [-pi/2, pi/2].
  always_comb begin
    z_in = CW'(angle) <<< (33 - ANGLE_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GAIN_Q30;
      y_r[0] <= '0;
      if (z_in > HALF_PI_Q30) begin
        z_r[0] <= z_in - PI_Q30; neg_r[0] <= 1'b1;
      end else if (z_in < -HALF_PI_Q30) begin
        z_r[0] <= z_in + PI_Q30; neg_r[0] <= 1'b1;
      end else begin
        z_r[0] <= z_in; neg_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_q30(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_q30(i);
        end
      end
    end
  end

  function automatic logic signed [COEF_BITS-1:0] to_coef(
      input logic signed [CW-1:0] v, input logic neg);
    logic signed [CW-1:0] t;
    logic signed [CW:0]   w;
    t = neg ? -v : v;
    if (t > ONE_Q30) t = ONE_Q30;
    else if (t < -ONE_Q30) t = -ONE_Q30;
    if (SH > 0) w = ((CW+1)'(t) + ((CW+1)'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
    else w = (CW+1)'(t) <<< (SH < 0 ? -SH : 0);
    return COEF_BITS'(w);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= to_coef(y_r[N], neg_r[N]);
      cos_r <= to_coef(x_r[N], neg_r[N]);
    end
  end
  assign sin_o = sin_r;
  assign cos_o = cos_r;
endmodule
`default_nettype wire

>>> rtl/core/eulr_matrix.sv
// Matrix stages: pair products, triple products, sums with saturation.
`default_nettype none
module eulr_matrix #(
  parameter int COEF_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [COEF_BITS-1:0] sx, cx, sy, cy, sz, cz,
  output logic signed [COEF_BITS-1:0]      m [0:8]
);
  localparam int F = COEF_BITS - 2;
  localparam int PW = 2 * COEF_BITS;
  localparam int SW = COEF_BITS + 2;

  function automatic logic signed [COEF_BITS:0] mulc(
      input logic signed [COEF_BITS:0] a, input logic signed [COEF_BITS:0] b);
    logic signed [PW+1:0] p;
    p = (PW+2)'(a) * (PW+2)'(b) + ((PW+2)'(1) <<< (F - 1));
    return (COEF_BITS+1)'(p >>> F);
  endfunction

  function automatic logic signed [COEF_BITS-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] one;
    one = SW'(1) <<< F;
    if (v > one) return COEF_BITS'(one);
    if (v < -one) return COEF_BITS'(-one);
    return COEF_BITS'(v);
  endfunction

  // Sign-extended coefficients, one bit of headroom.
  logic signed [COEF_BITS:0] sx_e, cx_e, sy_e, cy_e, sz_e, cz_e;
  assign sx_e = (COEF_BITS+1)'(sx);
  assign cx_e = (COEF_BITS+1)'(cx);
  assign sy_e = (COEF_BITS+1)'(sy);
  assign cy_e = (COEF_BITS+1)'(cy);
  assign sz_e = (COEF_BITS+1)'(sz);
  assign cz_e = (COEF_BITS+1)'(cz);

  // Stage A: pair products (|value| <= 1.0 so COEF_BITS+1 bits suffice).
  logic signed [COEF_BITS:0] cycz_r, cysz_r, sxsy_r, cxsy_r, cxsz_r, cxcz_r;
  logic signed [COEF_BITS:0] sxcy_r, sxsz_r, sxcz_r, cxcy_r, sya_r, sza_r, cza_r;
  always_ff @(posedge clk) begin
    if (en) begin
      cycz_r <= mulc(cy_e, cz_e); cysz_r <= mulc(cy_e, sz_e);
      sxsy_r <= mulc(sx_e, sy_e); cxsy_r <= mulc(cx_e, sy_e);
      cxsz_r <= mulc(cx_e, sz_e); cxcz_r <= mulc(cx_e, cz_e);
      sxcy_r <= mulc(sx_e, cy_e); sxsz_r <= mulc(sx_e, sz_e);
      sxcz_r <= mulc(sx_e, cz_e); cxcy_r <= mulc(cx_e, cy_e);
      sya_r <= sy_e; sza_r <= sz_e; cza_r <= cz_e;
    end
  end

  // Stage B: triple products.
  logic signed [COEF_BITS:0] p00_r, p01_r, p02_r, p12_r, p22_r, p10_r, p11_r, p20_r;
  logic signed [COEF_BITS:0] t0_r, t1_r, t2_r, t3_r, p21_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= cycz_r; p01_r <= cysz_r; p02_r <= sya_r;
      p12_r <= sxcy_r; p22_r <= cxcy_r;
      t0_r <= mulc(sxsy_r, cza_r); p10_r <= cxsz_r;
      t1_r <= mulc(sxsy_r, sza_r); p11_r <= cxcz_r;
      t2_r <= mulc(cxsy_r, cza_r); p20_r <= sxsz_r;
      t3_r <= mulc(cxsy_r, sza_r); p21_r <= sxcz_r;
    end
  end

  // Stage C: sums and saturation.
  logic signed [COEF_BITS-1:0] m_r [0:8];
  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= sat(SW'(p00_r));
      m_r[1] <= sat(-SW'(p01_r));
      m_r[2] <= sat(SW'(p02_r));
      m_r[3] <= sat(SW'(t0_r) + SW'(p10_r));
      m_r[4] <= sat(SW'(p11_r) - SW'(t1_r));
      m_r[5] <= sat(-SW'(p12_r));
      m_r[6] <= sat(SW'(p20_r) - SW'(t2_r));
      m_r[7] <= sat(SW'(t3_r) + SW'(p21_r));
      m_r[8] <= sat(SW'(p22_r));
    end
  end
  assign m = m_r;
endmodule
`default_nettype wire

>>> rtl/core/euler_xyz_rotation_matrix_core.sv
// Top level: Euler XYZ angles to rotation matrix, deep pipeline.
//
//  channel  dir  handshake          payload
//  in_      in   in_valid/in_ready  angle_x, angle_y, angle_z (Q3.13)
//  out_     out  out_valid/out_ready r00..r22 (Q2.14, saturated)
//
// Throughput one word per cycle while the output is not stalled; stages in order:
// fold, CORDIC steps, rounding, two product stages, sum stage, output register.
// Three CORDICs run side by side, one per axis.
// rst_n (synchronous) clears only the valid bits.
// Stall: the whole pipe freezes while the output word is held and not taken;
// in_ready is low only then, so no word is lost or repeated.
`default_nettype none
module euler_xyz_rotation_matrix_core
  import eulr_pkg::*;
#(
  parameter int ANGLE_BITS   = 16,
  parameter int COEF_BITS    = 16,
  parameter int SINCOS_STEPS = 14
) (
  input wire logic clk,
  input wire logic rst_n,
  eulr_in_if.sink   in_ch,
  eulr_out_if.source out_ch
);
  localparam int LAT = SINCOS_STEPS + 5;  // stages before output register

  logic en;
  logic [LAT:0] vld_r;  // vld_r[LAT] is the output register
  logic signed [COEF_BITS-1:0] sx, cx, sy, cy, sz, cz;
  logic signed [COEF_BITS-1:0] m [0:8];
  logic signed [COEF_BITS-1:0] o_r [0:8];

  // Advance when output slot is empty or being taken.
  assign en = !vld_r[LAT] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-1:0], in_ch.valid};
    end
  end

  eulr_cordic #(.ANGLE_BITS(ANGLE_BITS), .COEF_BITS(COEF_BITS),
                .SINCOS_STEPS(SINCOS_STEPS)) u_cx (
    .clk(clk), .en(en), .angle(in_ch.angle_x), .sin_o(sx), .cos_o(cx));
  eulr_cordic #(.ANGLE_BITS(ANGLE_BITS), .COEF_BITS(COEF_BITS),
                .SINCOS_STEPS(SINCOS_STEPS)) u_cy (
    .clk(clk), .en(en), .angle(in_ch.angle_y), .sin_o(sy), .cos_o(cy));
  eulr_cordic #(.ANGLE_BITS(ANGLE_BITS), .COEF_BITS(COEF_BITS),
                .SINCOS_STEPS(SINCOS_STEPS)) u_cz (
    .clk(clk), .en(en), .angle(in_ch.angle_z), .sin_o(sz), .cos_o(cz));

  eulr_matrix #(.COEF_BITS(COEF_BITS)) u_mat (
    .clk(clk), .en(en), .sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz),
    .m(m));

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      o_r <= m;
    end
  end

  assign out_ch.valid = vld_r[LAT];
  assign out_ch.r00 = o_r[0];
  assign out_ch.r01 = o_r[1];
  assign out_ch.r02 = o_r[2];
  assign out_ch.r10 = o_r[3];
  assign out_ch.r11 = o_r[4];
  assign out_ch.r12 = o_r[5];
  assign out_ch.r20 = o_r[6];
  assign out_ch.r21 = o_r[7];
  assign out_ch.r22 = o_r[8];
endmodule
`default_nettype wire

>>> rtl/core/eulr_checker.sv
// Checker: port-level properties of the rotation matrix core, with bind.
`default_nettype none
module eulr_checker #(
  parameter int COEF_BITS = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic signed [COEF_BITS-1:0] r00,
  input wire logic signed [COEF_BITS-1:0] r22
);
  localparam logic signed [COEF_BITS-1:0] ONE = COEF_BITS'(1) <<< (COEF_BITS - 2);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(r00))
    else $error("output word changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input blocked with free output slot");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (r00 <= ONE && r00 >= -ONE && r22 <= ONE && r22 >= -ONE))
    else $error("matrix entry out of range");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind euler_xyz_rotation_matrix_core eulr_checker #(.COEF_BITS(COEF_BITS)) u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .r00(out_ch.r00), .r22(out_ch.r22));
`default_nettype wire
